// ===== sv/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types, constants and the divisor helper function of the Taylor series engine.
// ----------------------------------------------------------------------------
package tss_pkg;

    // Fixed-point formats
    localparam int MAX_TERMS = 32;
    localparam int FRAC_BITS = 28;
    localparam int X_W       = 32;            // Q3.28 evaluation point
    localparam int RES_W     = 48;            // Q19.28 terms and sums
    localparam int IDX_W     = 6;
    localparam int SEL_W     = 2;

    // Multiplier: 48-bit magnitude times 35-bit factor in two 24-bit halves
    localparam int OPA_W     = RES_W;
    localparam int HALF_W    = OPA_W / 2;
    localparam int MB_W      = 35;
    localparam int PP_W      = HALF_W + MB_W;
    localparam int PROD_W    = OPA_W + MB_W;

    // Divider: 56-bit dividend, up to 12-bit divisor, 4 quotient bits a cycle
    localparam int QUO_W      = 56;
    localparam int DIV_W      = 12;
    localparam int DIV_BPC    = 4;
    localparam int DIV_CYCLES = QUO_W / DIV_BPC;
    localparam int DCNT_W     = $clog2(DIV_CYCLES);

    // Configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_FUNC  = 2'd0;
    localparam logic [1:0] REG_COUNT = 2'd1;
    localparam logic [1:0] REG_X     = 2'd2;

    // Function codes; the unused code behaves as sine
    localparam logic [SEL_W-1:0] FN_SINE     = 2'd0;
    localparam logic [SEL_W-1:0] FN_COSINE   = 2'd1;
    localparam logic [SEL_W-1:0] FN_EXP      = 2'd2;
    localparam logic [SEL_W-1:0] FN_SINE_ALT = 2'd3;

    localparam logic OP_SUM  = 1'b0;
    localparam logic OP_TERM = 1'b1;

    localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};
    localparam logic [RES_W-1:0]        FIX_ONE = RES_W'(1) << FRAC_BITS;
    localparam logic [PROD_W-1:0]       RND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_LOAD,
        ST_TERM_LOAD,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_ACC,
        ST_SQ_RND,
        ST_FIRST,
        ST_DIV_INIT,
        ST_DIV,
        ST_DIV_END,
        ST_ACC,
        ST_OUT
    } tss_state_t;

    typedef struct packed {
        logic             init;
        logic             sq_load;
        logic             term_load;
        logic             mul_lo;
        logic             mul_hi;
        logic             mul_acc;
        logic             sq_rnd;
        logic             first;
        logic             div_init;
        logic             div_step;
        logic             div_end;
        logic             accum;
        logic             out_load;
        logic             pick_term;
        logic [IDX_W-1:0] k;
    } tss_cmd_t;

    // Recurrence divisor for term k: k, 2k(2k+1) or 2k(2k-1)
    function automatic logic [DIV_W-1:0] tss_divisor(input logic [SEL_W-1:0] fsel,
                                                    input logic [IDX_W-1:0] k);
        logic [IDX_W:0]     tk;
        logic [2*IDX_W+1:0] p;
        tk = {k, 1'b0};
        p  = '0;
        case (fsel)
            FN_EXP:    p = (2*IDX_W+2)'(k);
            FN_COSINE: p = (2*IDX_W+2)'(tk) * (2*IDX_W+2)'(tk - (IDX_W+1)'(1));
            default:   p = (2*IDX_W+2)'(tk) * (2*IDX_W+2)'(tk + (IDX_W+1)'(1));
        endcase
        return p[DIV_W-1:0];
    endfunction

endpackage

// ===== sv/tss_regs.sv =====
// ----------------------------------------------------------------------------
// tss_regs
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module tss_regs import tss_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready,
    output logic [SEL_W-1:0]        function_select,
    output logic [IDX_W-1:0]        term_count,
    output logic signed [X_W-1:0]   x_value
);

    logic [SEL_W-1:0]      func_reg, func_next;
    logic [IDX_W-1:0]      count_reg, count_next;
    logic signed [X_W-1:0] x_reg, x_next;
    logic                  wr_en;
    logic [1:0]            reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[3:2];

    always_comb begin
        func_next  = func_reg;
        count_next = count_reg;
        x_next     = x_reg;
        if (wr_en) begin
            case (reg_sel)
                REG_FUNC:  func_next  = pwdata[SEL_W-1:0];
                REG_COUNT: count_next = pwdata[IDX_W-1:0];
                REG_X:     x_next     = pwdata[X_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            func_reg  <= FN_SINE;
            count_reg <= IDX_W'(1);
            x_reg     <= '0;
        end else begin
            func_reg  <= func_next;
            count_reg <= count_next;
            x_reg     <= x_next;
        end
    end

    always_comb begin
        case (reg_sel)
            REG_FUNC:  prdata = DATA_W'(func_reg);
            REG_COUNT: prdata = DATA_W'(count_reg);
            REG_X:     prdata = DATA_W'(x_reg);
            default:   prdata = '0;
        endcase
    end

    assign function_select = func_reg;
    assign term_count      = count_reg;
    assign x_value         = x_reg;

endmodule

// ===== sv/tss_dp.sv =====
// ----------------------------------------------------------------------------
// tss_dp
// Datapath: split multiplier, radix-16 divider, term and sum registers.
// ----------------------------------------------------------------------------
module tss_dp import tss_pkg::*; (
    input  logic                      aclk,
    input  tss_cmd_t                  cmd,
    input  logic [SEL_W-1:0]          function_select,
    input  logic signed [X_W-1:0]     x_value,
    output logic signed [RES_W-1:0]   result_value,
    output logic                      overflow
);

    logic [OPA_W-1:0]        opa_reg;
    logic [MB_W-1:0]         mb_reg;
    logic [PP_W-1:0]         pp_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [MB_W-1:0]         xsq_reg;
    logic [QUO_W-1:0]        quo_reg;
    logic [DIV_W-1:0]        rem_reg;
    logic [DIV_W-1:0]        d_reg;
    logic                    neg_reg;
    logic signed [RES_W-1:0] term_reg;
    logic signed [RES_W-1:0] sum_reg;
    logic                    ovf_reg;
    logic signed [RES_W-1:0] res_reg;
    logic                    ovf_out_reg;

    logic                    x_neg, term_neg, is_exp, is_sine;
    logic [X_W-1:0]          x_abs;
    logic [OPA_W-1:0]        term_abs;
    logic [HALF_W-1:0]       opa_half;
    logic [PP_W-1:0]         pp_w;
    logic [PROD_W-1:0]       rnd;
    logic [QUO_W-1:0]        quo_step;
    logic [DIV_W-1:0]        rem_step;
    logic [DIV_W:0]          rem_try;
    logic [QUO_W:0]          r_full, r_lim, r_sat;
    logic [RES_W-1:0]        term_new;
    logic                    term_sat;
    logic signed [RES_W:0]   sum_wide;
    logic signed [RES_W-1:0] sum_new;
    logic                    sum_sat;

    assign x_neg    = x_value[X_W-1];
    assign x_abs    = x_neg ? X_W'(-x_value) : X_W'(x_value);
    assign term_neg = term_reg[RES_W-1];
    assign term_abs = term_neg ? OPA_W'(-term_reg) : OPA_W'(term_reg);
    assign is_exp   = (function_select == FN_EXP);
    assign is_sine  = (function_select == FN_SINE) || (function_select == FN_SINE_ALT);

    // one 24x35 multiplier, used for the low then the high half of opa
    assign opa_half = cmd.mul_hi ? opa_reg[OPA_W-1:HALF_W] : opa_reg[HALF_W-1:0];
    assign pp_w     = PP_W'(opa_half) * PP_W'(mb_reg);
    assign rnd      = prod_reg + RND_HALF;

    // four restoring divide steps a cycle; remainder stays below the divisor
    always_comb begin
        quo_step = quo_reg;
        rem_step = rem_reg;
        rem_try  = '0;
        for (int i = 0; i < DIV_BPC; i++) begin
            rem_try  = {rem_step, quo_step[QUO_W-1]};
            quo_step = {quo_step[QUO_W-2:0], 1'b0};
            if (rem_try >= {1'b0, d_reg}) begin
                rem_try     = rem_try - {1'b0, d_reg};
                quo_step[0] = 1'b1;
            end
            rem_step = rem_try[DIV_W-1:0];
        end
    end

    // round half up, clamp to 2^47-1 or 2^47, then apply the sign
    always_comb begin
        r_full   = {1'b0, quo_reg} + (QUO_W+1)'({rem_reg, 1'b0} >= {1'b0, d_reg});
        r_lim    = {{(QUO_W-RES_W+1){1'b0}}, neg_reg, {(RES_W-1){~neg_reg}}};
        term_sat = (r_full > r_lim);
        r_sat    = term_sat ? r_lim : r_full;
        term_new = neg_reg ? RES_W'(-r_sat[RES_W-1:0]) : r_sat[RES_W-1:0];
    end

    always_comb begin
        sum_wide = {sum_reg[RES_W-1], sum_reg} + {term_reg[RES_W-1], term_reg};
        sum_sat  = (sum_wide[RES_W] != sum_wide[RES_W-1]);
        if (sum_sat) begin
            sum_new = sum_wide[RES_W] ? RES_MIN : RES_MAX;
        end else begin
            sum_new = sum_wide[RES_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.init) begin
            term_reg <= '0;
            sum_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        if (cmd.sq_load) begin
            opa_reg <= OPA_W'(x_abs);
            mb_reg  <= MB_W'(x_abs);
        end
        if (cmd.term_load) begin
            opa_reg <= term_abs;
            mb_reg  <= is_exp ? MB_W'(x_abs) : xsq_reg;
            neg_reg <= is_exp ? (term_neg ^ x_neg) : ~term_neg;
            d_reg   <= tss_divisor(function_select, cmd.k);
        end
        if (cmd.mul_lo || cmd.mul_hi) begin
            pp_reg <= pp_w;
        end
        if (cmd.mul_hi) begin
            prod_reg <= PROD_W'(pp_reg);
        end
        if (cmd.mul_acc) begin
            prod_reg <= prod_reg + (PROD_W'(pp_reg) << HALF_W);
        end
        if (cmd.sq_rnd) begin
            xsq_reg <= rnd[FRAC_BITS+MB_W-1:FRAC_BITS];
        end
        if (cmd.first) begin
            term_reg <= is_sine ? RES_W'(x_value) : FIX_ONE;
        end
        if (cmd.div_init) begin
            quo_reg <= QUO_W'(rnd[PROD_W-1:FRAC_BITS]);
            rem_reg <= '0;
        end
        if (cmd.div_step) begin
            quo_reg <= quo_step;
            rem_reg <= rem_step;
        end
        if (cmd.div_end) begin
            term_reg <= term_new;
            if (term_sat) begin
                ovf_reg <= 1'b1;
            end
        end
        if (cmd.accum) begin
            sum_reg <= sum_new;
            if (sum_sat) begin
                ovf_reg <= 1'b1;
            end
        end
        if (cmd.out_load) begin
            res_reg     <= cmd.pick_term ? term_reg : sum_reg;
            ovf_out_reg <= ovf_reg;
        end
    end

    assign result_value = res_reg;
    assign overflow     = ovf_out_reg;

endmodule

// ===== sv/tss_ctrl.sv =====
// ----------------------------------------------------------------------------
// tss_ctrl
// Sequencer: request decode, term loop, multiply/divide steps, output stage.
// ----------------------------------------------------------------------------
module tss_ctrl import tss_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             req_op,
    input  logic [IDX_W-1:0] req_index,
    input  logic [IDX_W-1:0] term_count,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic             index_error,
    output tss_cmd_t         cmd
);

    tss_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [IDX_W-1:0]  last_reg, last_next;
    logic              op_reg, op_next;
    logic              ierr_reg, ierr_next;
    logic              sq_reg, sq_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              ierr_out_reg, ierr_out_next;

    logic [IDX_W-1:0]  cnt_eff;
    logic              ierr_in;
    logic [IDX_W-1:0]  last_in;

    assign cnt_eff = (term_count > IDX_W'(MAX_TERMS)) ? IDX_W'(MAX_TERMS) : term_count;
    assign ierr_in = (req_op == OP_TERM) && (req_index > cnt_eff);
    assign last_in = (req_op == OP_TERM) ? (ierr_in ? '0 : req_index) : cnt_eff;

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        last_next  = last_reg;
        op_next    = op_reg;
        ierr_next  = ierr_reg;
        sq_next    = sq_reg;
        dcnt_next  = dcnt_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.k         = k_reg;
        cmd.pick_term = (op_reg == OP_TERM);

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.init   = 1'b1;
                    op_next    = req_op;
                    ierr_next  = ierr_in;
                    last_next  = last_in;
                    k_next     = '0;
                    state_next = (last_in == '0) ? ST_OUT : ST_SQ_LOAD;
                end
            end
            ST_SQ_LOAD: begin
                cmd.sq_load = 1'b1;
                sq_next     = 1'b1;
                state_next  = ST_MUL_LO;
            end
            ST_TERM_LOAD: begin
                cmd.term_load = 1'b1;
                sq_next       = 1'b0;
                state_next    = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_MUL_ACC;
            end
            ST_MUL_ACC: begin
                cmd.mul_acc = 1'b1;
                state_next  = sq_reg ? ST_SQ_RND : ST_DIV_INIT;
            end
            ST_SQ_RND: begin
                cmd.sq_rnd = 1'b1;
                state_next = ST_FIRST;
            end
            ST_FIRST: begin
                cmd.first  = 1'b1;
                state_next = ST_ACC;
            end
            ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
                dcnt_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (dcnt_reg == DCNT_W'(DIV_CYCLES - 1)) begin
                    state_next = ST_DIV_END;
                end else begin
                    dcnt_next = dcnt_reg + DCNT_W'(1);
                end
            end
            ST_DIV_END: begin
                cmd.div_end = 1'b1;
                state_next  = ST_ACC;
            end
            ST_ACC: begin
                cmd.accum = (op_reg == OP_SUM);
                if (k_reg + IDX_W'(1) == last_reg) begin
                    state_next = ST_OUT;
                end else begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = ST_TERM_LOAD;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        ierr_out_next = ierr_out_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
            ierr_out_next = ierr_reg;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg        <= k_next;
        last_reg     <= last_next;
        op_reg       <= op_next;
        ierr_reg     <= ierr_next;
        sq_reg       <= sq_next;
        dcnt_reg     <= dcnt_next;
        ierr_out_reg <= ierr_out_next;
    end

    assign m_tvalid    = m_tvalid_reg;
    assign index_error = ierr_out_reg;

`ifndef ASSERT_OFF
    a_term_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACC) |-> (k_reg < last_reg))
        else $error("term counter past the last term");

    a_div_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV_END) |->
            ($past(state_reg) == ST_DIV && $past(dcnt_reg) == DCNT_W'(DIV_CYCLES - 1)))
        else $error("divide finished early");

    a_ierr_no_terms: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE && ierr_reg) |-> (op_reg == OP_TERM && last_reg == '0))
        else $error("index error with terms scheduled");

    a_out_no_clobber: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |-> !cmd.out_load)
        else $error("pending result overwritten");
`endif

endmodule

// ===== sv/taylor_series_sin_cos_exp.sv =====
// ----------------------------------------------------------------------------
// taylor_series_sin_cos_exp
// Truncated Taylor series of sine, cosine or exp in fixed point (Q19.28).
// ----------------------------------------------------------------------------
//  channel | ports         | payload
//  --------+---------------+---------------------------------------------------
//  request | s_t*          | tuser: opcode; tdata[5:0]: element_index
//  result  | m_t*          | tdata[47:0]: result_value; tuser: index_error, overflow
//  config  | p* (APB)      | 0x0 function_select, 0x4 term_count, 0x8 x_value
//
//  A request with N = 0 goes straight to the output stage; each term after the first
//  costs a split multiply (low half, high half, accumulate) and a divider run at
//  4 quotient bits a cycle.
//  One request is worked at a time; the next transfer is taken while a result
//  still waits in the output register. Synchronous active-low reset, no clearing pass.
// ----------------------------------------------------------------------------
module taylor_series_sin_cos_exp import tss_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [5:0] element_index, [7:6] zero
    input  logic              s_tuser,   // [0] opcode
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [RES_W-1:0]  m_tdata,   // [47:0] result_value
    output logic [1:0]        m_tuser,   // [0] index_error, [1] overflow
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [SEL_W-1:0]        function_select;
    logic [IDX_W-1:0]        term_count;
    logic signed [X_W-1:0]   x_value;
    tss_cmd_t                cmd;
    logic signed [RES_W-1:0] result_value;
    logic                    index_error;
    logic                    overflow;

    tss_regs u_regs (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .function_select (function_select),
        .term_count      (term_count),
        .x_value         (x_value)
    );

    tss_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .req_op      (s_tuser),
        .req_index   (s_tdata[IDX_W-1:0]),
        .term_count  (term_count),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .index_error (index_error),
        .cmd         (cmd)
    );

    tss_dp u_dp (
        .aclk            (aclk),
        .cmd             (cmd),
        .function_select (function_select),
        .x_value         (x_value),
        .result_value    (result_value),
        .overflow        (overflow)
    );

    assign m_tdata = result_value;
    assign m_tuser = {overflow, index_error};

endmodule

// ===== tb/taylor_series_sin_cos_exp_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taylor_series_sin_cos_exp_tb
// Drives sum and single-term requests through the stream ports under several
// register settings (every function code, term counts from zero past the
// limit, x at both ends of its range) and checks each result against a
// fixed-point series predictor, with random idling on both channels.
// ----------------------------------------------------------------------------
module taylor_series_sin_cos_exp_tb;
    import tss_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 700;

    typedef struct packed {
        logic [RES_W-1:0] value;
        logic             index_error;
        logic             overflow;
    } series_result_t;

    // Keeps a copy of the three registers and the results still owed.
    class series_scoreboard;
        logic [SEL_W-1:0]        func_sel = FN_SINE;
        logic [IDX_W-1:0]        n_terms  = 6'd1;
        logic signed [X_W-1:0]   x_point  = '0;
        series_result_t          pending[$];
        int                      errors   = 0;
        bit                      sat_seen;

        function void set_register(logic [1:0] reg_idx, logic [DATA_W-1:0] value);
            case (reg_idx)
                REG_FUNC:  func_sel = value[SEL_W-1:0];
                REG_COUNT: n_terms  = value[IDX_W-1:0];
                REG_X:     x_point  = value[X_W-1:0];
                default: ;
            endcase
        endfunction

        // One recurrence step on magnitudes, sign applied at the end.
        function logic signed [63:0] next_term(logic signed [63:0] prev, int k,
                                               logic [SEL_W-1:0] sel, logic [63:0] xsq);
            logic                neg, xneg;
            logic signed [63:0]  x64;
            logic [63:0]         mag, m, d, q, r, lim;
            logic [127:0]        p;
            x64  = x_point;
            neg  = prev[63];
            mag  = neg ? 64'(-prev) : 64'(prev);
            if (sel == FN_EXP) begin
                xneg = x64[63];
                m    = xneg ? 64'(-x64) : 64'(x64);
                d    = 64'(k);
                neg  = neg ^ xneg;
            end else begin
                m   = xsq;
                d   = (sel == FN_SINE) ? 64'(2 * k) * 64'(2 * k + 1)
                                       : 64'(2 * k) * 64'(2 * k - 1);
                neg = !neg;
            end
            p = {64'd0, mag} * {64'd0, m} + (128'd1 << (FRAC_BITS - 1));
            if (p[127:64+FRAC_BITS] != '0) begin
                sat_seen = 1'b1;
                q = '1;
            end else begin
                q = p[63+FRAC_BITS:FRAC_BITS];
            end
            r   = q / d + ((((q % d) * 64'd2) >= d) ? 64'd1 : 64'd0);
            lim = neg ? 64'(RES_MAX) + 64'd1 : 64'(RES_MAX);
            if (r > lim) begin
                r        = lim;
                sat_seen = 1'b1;
            end
            return neg ? -$signed(r) : $signed(r);
        endfunction

        function series_result_t evaluate(logic op, logic [IDX_W-1:0] idx);
            logic [SEL_W-1:0]    sel;
            logic signed [63:0]  x64, acc, t;
            logic [63:0]         sq, xsq;
            int                  cnt, last;
            series_result_t      res;
            sel  = (func_sel == FN_SINE_ALT) ? FN_SINE : func_sel;
            cnt  = (n_terms > MAX_TERMS) ? MAX_TERMS : int'(n_terms);
            x64  = x_point;
            sq   = x64 * x64;
            xsq  = (sq + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            acc  = '0;
            t    = '0;
            sat_seen = 1'b0;
            res.index_error = 1'b0;
            if (op == OP_TERM) begin
                if (int'(idx) > cnt) begin
                    res.index_error = 1'b1;
                    last = 0;
                end else begin
                    last = int'(idx);
                end
            end else begin
                last = cnt;
            end
            for (int k = 0; k < last; k++) begin
                if (k == 0)
                    t = (sel == FN_SINE) ? x64 : $signed({16'd0, FIX_ONE});
                else
                    t = next_term(t, k, sel, xsq);
                if (op == OP_SUM) begin
                    acc = acc + t;
                    if (acc > RES_MAX) begin
                        acc      = RES_MAX;
                        sat_seen = 1'b1;
                    end else if (acc < RES_MIN) begin
                        acc      = RES_MIN;
                        sat_seen = 1'b1;
                    end
                end
            end
            if (op == OP_TERM)
                acc = t;
            res.value    = acc[RES_W-1:0];
            res.overflow = sat_seen;
            return res;
        endfunction

        function void note_request(logic op, logic [IDX_W-1:0] idx);
            pending.push_back(evaluate(op, idx));
        endfunction

        function void check_result(logic [RES_W-1:0] value, logic [1:0] flags);
            series_result_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result with nothing outstanding: value=%h ierr=%b ovf=%b",
                             $realtime, value, flags[0], flags[1]);
                return;
            end
            want = pending.pop_front();
            if (value !== want.value || flags[0] !== want.index_error ||
                flags[1] !== want.overflow) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch: value exp %h got %h, ierr exp %b got %b, ovf exp %b got %b",
                             $realtime, want.value, value, want.index_error, flags[0],
                             want.overflow, flags[1]);
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = '0;   // [5:0] element_index, [7:6] zero
    logic              s_tuser  = 1'b0; // [0] opcode
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [RES_W-1:0]  m_tdata;         // [47:0] result_value
    logic [1:0]        m_tuser;         // [0] index_error, [1] overflow
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [DATA_W-1:0] pwdata   = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    series_scoreboard board = new();
    int send_idle_pct = 27;
    int recv_idle_pct = 55;
    int hold_len      = 0;
    int cycles        = 0;

    taylor_series_sin_cos_exp dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("taylor_series_sin_cos_exp_tb: errors");
        $finish;
    end

    // Result side: check every transfer, then pick ready for the next edge.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                board.check_result(m_tdata, m_tuser);
            if (hold_len > 0) begin
                m_tready <= 1'b0;
                hold_len <= hold_len - 1;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Leaves s_tvalid high after the transfer; callers lower it before waiting.
    task automatic send_request(input logic op, input logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, idx};
        do @(posedge aclk); while (!s_tready);
        board.note_request(op, idx);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] reg_idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_register(reg_idx, value);
        @(posedge aclk);
    endtask

    // Registers change only with the engine idle.
    task automatic configure(input logic [SEL_W-1:0] sel, input logic [IDX_W-1:0] cnt,
                             input logic [X_W-1:0] x);
        wait_for_results();
        write_register(REG_FUNC, DATA_W'(sel));
        write_register(REG_COUNT, DATA_W'(cnt));
        write_register(REG_X, x);
    endtask

    initial begin
        logic [SEL_W-1:0] sel;
        logic [IDX_W-1:0] cnt, idx;
        logic [X_W-1:0]   x;
        logic [31:0]      rnd;
        logic             op;
        int               r, lim;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: sine, one term, x = 0
        send_request(OP_SUM, 6'h3F);
        send_request(OP_TERM, 6'd1);
        send_request(OP_TERM, 6'd0);
        send_request(OP_TERM, 6'd2);

        configure(FN_SINE, 6'd32, 32'h7FFF_FFFF);
        send_request(OP_SUM, 6'd0);
        send_request(OP_TERM, 6'd32);
        send_request(OP_TERM, 6'd33);
        send_request(OP_TERM, 6'd63);

        // count above the limit behaves as 32
        configure(FN_COSINE, 6'd63, 32'h8000_0000);
        send_request(OP_SUM, 6'd5);
        send_request(OP_TERM, 6'd32);
        send_request(OP_TERM, 6'd33);
        send_request(OP_TERM, 6'd0);

        configure(FN_EXP, 6'd0, 32'hE800_0000);   // x = -1.5
        send_request(OP_SUM, 6'd0);
        send_request(OP_TERM, 6'd1);
        send_request(OP_TERM, 6'd0);

        configure(FN_EXP, 6'd20, 32'h8000_0000);
        send_request(OP_SUM, 6'd0);
        send_request(OP_TERM, 6'd20);
        send_request(OP_TERM, 6'd1);
        send_request(OP_TERM, 6'd13);

        // unused function code acts as sine; x = -pi/2
        configure(FN_SINE_ALT, 6'd7, 32'hE6DE_04AC);
        send_request(OP_SUM, 6'd0);
        send_request(OP_TERM, 6'd7);
        send_request(OP_TERM, 6'd4);

        for (int ph = 0; ph < 30; ph++) begin
            send_idle_pct = (ph < 10) ? 27 : ((ph < 20) ? 55 : 0);
            recv_idle_pct = (ph < 10) ? 55 : ((ph < 20) ? 27 : 0);

            sel = SEL_W'($urandom_range(3));
            r   = $urandom_range(99);
            if (r < 60)
                cnt = IDX_W'($urandom_range(8));
            else if (r < 85)
                cnt = IDX_W'($urandom_range(20, 9));
            else if (r < 95)
                cnt = IDX_W'($urandom_range(32, 21));
            else
                cnt = IDX_W'($urandom_range(63, 33));
            r   = $urandom_range(99);
            rnd = $urandom;
            if (r < 5)
                x = 32'h8000_0000;
            else if (r < 10)
                x = 32'h7FFF_FFFF;
            else if (r < 15)
                x = rnd[0] ? 32'd1 : 32'hFFFF_FFFF;
            else if (r < 55)
                x = rnd;
            else
                x = {{2{rnd[29]}}, rnd[29:0]};
            configure(sel, cnt, x);

            // long receiver stall so the engine backs up into the request side
            if (ph == 4 || ph == 14)
                hold_len <= HOLD_CYCLES;

            lim = (cnt > MAX_TERMS) ? MAX_TERMS : int'(cnt);
            for (int i = 0; i < 25; i++) begin
                if (ph == 12 && i == 12)
                    wait_for_results();
                op = 1'($urandom_range(1));
                if (op == OP_TERM && $urandom_range(99) < 70)
                    idx = IDX_W'($urandom_range(lim + 1));
                else
                    idx = IDX_W'($urandom_range(63));
                send_request(op, idx);
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("taylor_series_sin_cos_exp_tb: clean");
        else
            $display("taylor_series_sin_cos_exp_tb: errors");
        $finish;
    end

endmodule
